FILE: rtl/szc_pkg.sv
package szc_pkg;

    // Default configuration
    localparam int DEF_NUM_CLASSES          = 8;
    localparam int DEF_TOTAL_BLOCKS         = 512;
    localparam int DEF_SMALLEST_BLOCK_BYTES = 16;

    // Word field widths
    localparam int REQ_W    = 20;
    localparam int HCLS_W   = 3;
    localparam int HIDX_W   = 6;
    localparam int FCNT_W   = 7;
    localparam int SUM_W    = 48;
    localparam int STATUS_W = 3;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 112;

    typedef enum logic
    {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } command_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK          = 3'd0,
        ST_ZERO_SIZE   = 3'd1,
        ST_TOO_LARGE   = 3'd2,
        ST_CLASS_EMPTY = 3'd3,
        ST_BAD_HANDLE  = 3'd4,
        ST_NOT_IN_USE  = 3'd5
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_FINISH = 2'd2
    } state_t;

    // Controller to datapath
    typedef struct packed
    {
        logic accept;   // take input word, issue table reads
        logic exec;     // apply the request to the pool state
        logic finish;   // settle peak, load the output word
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed
    {
        logic out_slot_free;
    } ctrl_stat_t;

endpackage

FILE: rtl/szc_ctrl.sv
module szc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  szc_pkg::ctrl_stat_t stat,
    output szc_pkg::ctrl_cmd_t  cmd
);

    szc_pkg::state_t state_reg;
    szc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= szc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            szc_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = szc_pkg::S_EXEC;
                end
            end
            szc_pkg::S_EXEC:
            begin
                state_next = szc_pkg::S_FINISH;
            end
            szc_pkg::S_FINISH:
            begin
                // hold until the output register can take the result
                if (stat.out_slot_free)
                begin
                    state_next = s_tvalid ? szc_pkg::S_EXEC : szc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = szc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd.exec   = 1'b0;
        cmd.finish = 1'b0;
        unique case (state_reg)
            szc_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
            end
            szc_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            szc_pkg::S_FINISH:
            begin
                s_tready   = stat.out_slot_free;
                cmd.finish = stat.out_slot_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
        cmd.accept = s_tvalid && s_tready;
    end

endmodule

FILE: rtl/szc_datapath.sv
module szc_datapath
#(
    parameter int NUM_CLASSES          = szc_pkg::DEF_NUM_CLASSES,
    parameter int TOTAL_BLOCKS         = szc_pkg::DEF_TOTAL_BLOCKS,
    parameter int SMALLEST_BLOCK_BYTES = szc_pkg::DEF_SMALLEST_BLOCK_BYTES
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  szc_pkg::ctrl_cmd_t                  cmd,
    output szc_pkg::ctrl_stat_t                 stat,
    input  logic                                in_command,
    input  logic [szc_pkg::REQ_W-1:0]           in_request_bytes,
    input  logic [szc_pkg::HCLS_W-1:0]          in_handle_class,
    input  logic [szc_pkg::HIDX_W-1:0]          in_handle_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [szc_pkg::STATUS_W-1:0]        out_status,
    output logic [szc_pkg::HCLS_W-1:0]          out_granted_class,
    output logic [szc_pkg::HIDX_W-1:0]          out_granted_index,
    output logic [szc_pkg::FCNT_W-1:0]          out_class_free_count,
    output logic [szc_pkg::SUM_W-1:0]           out_bytes_allocated_total,
    output logic [szc_pkg::SUM_W-1:0]           out_bytes_peak_in_use
);

    localparam int CAP    = TOTAL_BLOCKS / NUM_CLASSES;
    localparam int IDX_W  = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int CNT_W  = $clog2(CAP + 1);
    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int DEPTH  = NUM_CLASSES * CAP;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = 16;
    localparam int BYT_W  = szc_pkg::REQ_W + 1;
    localparam int SUM_W  = szc_pkg::SUM_W;

    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAP);
    localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};

    // Free-index stacks and in-use bits. Entries at or above a class's high-water
    // mark were never written and are taken as their reset values.
    logic [IDX_W-1:0] stack_mem [DEPTH];
    logic             inuse_mem [DEPTH];

    logic [CNT_W-1:0] tops_reg [NUM_CLASSES];
    logic [CNT_W-1:0] tops_next;
    logic [CNT_W-1:0] hw_reg   [NUM_CLASSES];
    logic [CNT_W-1:0] hw_next;
    logic             tab_we;

    // Request latched at accept
    logic                      cmd_reg;
    logic                      zero_reg;
    logic                      too_large_reg;
    logic                      bad_cls_reg;
    logic [CLS_W-1:0]          cls_reg;
    logic [szc_pkg::HCLS_W-1:0] hc_reg;
    logic [szc_pkg::HIDX_W-1:0] hi_reg;
    logic [CNT_W-1:0]          top_cur_reg;
    logic [CNT_W-1:0]          hw_cur_reg;
    logic [IDX_W-1:0]          stack_rd_reg;
    logic                      inuse_rd_reg;

    // Result of the exec step
    logic [szc_pkg::STATUS_W-1:0] res_status_reg;
    logic [szc_pkg::STATUS_W-1:0] res_status_next;
    logic [szc_pkg::HCLS_W-1:0]   res_gc_reg;
    logic [szc_pkg::HCLS_W-1:0]   res_gc_next;
    logic [szc_pkg::HIDX_W-1:0]   res_gi_reg;
    logic [szc_pkg::HIDX_W-1:0]   res_gi_next;
    logic [szc_pkg::FCNT_W-1:0]   res_fc_reg;
    logic [szc_pkg::FCNT_W-1:0]   res_fc_next;
    logic                         alloc_ok_reg;
    logic                         alloc_ok_next;

    logic [SUM_W-1:0] alloc_sum_reg;
    logic [SUM_W-1:0] alloc_sum_next;
    logic [SUM_W-1:0] freed_sum_reg;
    logic [SUM_W-1:0] freed_sum_next;
    logic [SUM_W-1:0] peak_sum_reg;
    logic [SUM_W-1:0] peak_sum_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [szc_pkg::STATUS_W-1:0] out_status_reg;
    logic [szc_pkg::HCLS_W-1:0]   out_gc_reg;
    logic [szc_pkg::HIDX_W-1:0]   out_gi_reg;
    logic [szc_pkg::FCNT_W-1:0]   out_fc_reg;
    logic [SUM_W-1:0]             out_total_reg;
    logic [SUM_W-1:0]             out_peak_reg;

    // ---------------- accept-side lookup ----------------
    logic [NUM_CLASSES-1:0] fits;
    logic [CLS_W-1:0]       fit_cls;
    logic [CLS_W-1:0]       acc_cls;
    logic [CNT_W-1:0]       acc_top;
    logic [ADDR_W:0]        acc_base;
    logic [ADDR_W-1:0]      stack_rd_addr;
    logic [ADDR_W-1:0]      inuse_rd_addr;

    always_comb
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            fits[c] = {1'b0, in_request_bytes} <= (BYT_W'(SMALLEST_BLOCK_BYTES) << c);
        end
        fit_cls = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if (fits[c])
            begin
                fit_cls = CLS_W'(c);
            end
        end
        acc_cls       = (in_command == szc_pkg::CMD_ALLOC) ? fit_cls : CLS_W'(in_handle_class);
        acc_top       = tops_reg[acc_cls];
        acc_base      = (ADDR_W+1)'(acc_cls) * (ADDR_W+1)'(CAP);
        stack_rd_addr = ADDR_W'(acc_base + (ADDR_W+1)'(acc_top));
        inuse_rd_addr = ADDR_W'(acc_base + (ADDR_W+1)'(in_handle_index));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg       <= in_command;
            zero_reg      <= (in_request_bytes == '0);
            too_large_reg <= (fits == '0);
            bad_cls_reg   <= ({1'b0, in_handle_class} >= (szc_pkg::HCLS_W+1)'(NUM_CLASSES));
            cls_reg       <= acc_cls;
            hc_reg        <= in_handle_class;
            hi_reg        <= in_handle_index;
            top_cur_reg   <= acc_top;
            hw_cur_reg    <= hw_reg[acc_cls];
            stack_rd_reg  <= stack_mem[stack_rd_addr];
            inuse_rd_reg  <= inuse_mem[inuse_rd_addr];
        end
    end

    // ---------------- exec step ----------------
    logic [IDX_W-1:0]   pop_idx;
    logic               inuse_val;
    logic               hi_bad;
    logic [ADDR_W:0]    cls_base;
    logic [ADDR_W-1:0]  inuse_wr_addr;
    logic               inuse_wr_val;
    logic               inuse_we;
    logic [ADDR_W-1:0]  stack_wr_addr;
    logic               stack_we;
    logic [SUM_W:0]     alloc_add;
    logic [SUM_W:0]     freed_add;
    logic [SUM_W-1:0]   cls_bytes;

    always_comb
    begin
        pop_idx   = (top_cur_reg >= hw_cur_reg) ? top_cur_reg[IDX_W-1:0] : stack_rd_reg;
        hi_bad    = (CMP_W'(hi_reg) >= CMP_W'(CAP));
        inuse_val = (CMP_W'(hi_reg) >= CMP_W'(hw_cur_reg)) ? 1'b0 : inuse_rd_reg;
        cls_base  = (ADDR_W+1)'(cls_reg) * (ADDR_W+1)'(CAP);
        cls_bytes = SUM_W'(SMALLEST_BLOCK_BYTES) << cls_reg;
        alloc_add = {1'b0, alloc_sum_reg} + {1'b0, cls_bytes};
        freed_add = {1'b0, freed_sum_reg} + {1'b0, cls_bytes};

        res_status_next = szc_pkg::ST_OK;
        res_gc_next     = '0;
        res_gi_next     = '0;
        res_fc_next     = '0;
        alloc_ok_next   = 1'b0;
        tops_next       = top_cur_reg;
        hw_next         = hw_cur_reg;
        tab_we          = 1'b0;
        inuse_we        = 1'b0;
        inuse_wr_val    = 1'b0;
        inuse_wr_addr   = ADDR_W'(cls_base + (ADDR_W+1)'(hi_reg));
        stack_we        = 1'b0;
        stack_wr_addr   = ADDR_W'(cls_base + (ADDR_W+1)'(top_cur_reg - 1'b1));
        alloc_sum_next  = alloc_sum_reg;
        freed_sum_next  = freed_sum_reg;

        if (cmd_reg == szc_pkg::CMD_ALLOC)
        begin
            priority if (zero_reg)
            begin
                res_status_next = szc_pkg::ST_ZERO_SIZE;
            end
            else if (too_large_reg)
            begin
                res_status_next = szc_pkg::ST_TOO_LARGE;
            end
            else if (top_cur_reg >= CAP_CNT)
            begin
                res_status_next = szc_pkg::ST_CLASS_EMPTY;
                res_gc_next     = szc_pkg::HCLS_W'(cls_reg);
            end
            else
            begin
                tops_next      = top_cur_reg + 1'b1;
                hw_next        = (tops_next > hw_cur_reg) ? tops_next : hw_cur_reg;
                tab_we         = 1'b1;
                inuse_we       = 1'b1;
                inuse_wr_val   = 1'b1;
                inuse_wr_addr  = ADDR_W'(cls_base + (ADDR_W+1)'(pop_idx));
                alloc_sum_next = alloc_add[SUM_W] ? SUM_MAX : alloc_add[SUM_W-1:0];
                alloc_ok_next  = 1'b1;
                res_gc_next    = szc_pkg::HCLS_W'(cls_reg);
                res_gi_next    = szc_pkg::HIDX_W'(pop_idx);
                res_fc_next    = szc_pkg::FCNT_W'(CAP_CNT - tops_next);
            end
        end
        else
        begin
            res_gc_next = hc_reg;
            res_gi_next = hi_reg;
            priority if (bad_cls_reg)
            begin
                res_status_next = szc_pkg::ST_BAD_HANDLE;
            end
            else if (hi_bad)
            begin
                res_status_next = szc_pkg::ST_BAD_HANDLE;
                res_fc_next     = szc_pkg::FCNT_W'(CAP_CNT - top_cur_reg);
            end
            else if (!inuse_val || top_cur_reg == '0)
            begin
                res_status_next = szc_pkg::ST_NOT_IN_USE;
                res_fc_next     = szc_pkg::FCNT_W'(CAP_CNT - top_cur_reg);
            end
            else
            begin
                tops_next      = top_cur_reg - 1'b1;
                tab_we         = 1'b1;
                inuse_we       = 1'b1;
                stack_we       = 1'b1;
                freed_sum_next = freed_add[SUM_W] ? SUM_MAX : freed_add[SUM_W-1:0];
                res_fc_next    = szc_pkg::FCNT_W'(CAP_CNT - tops_next);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && stack_we)
        begin
            stack_mem[stack_wr_addr] <= IDX_W'(hi_reg);
        end
        if (cmd.exec && inuse_we)
        begin
            inuse_mem[inuse_wr_addr] <= inuse_wr_val;
        end
        if (cmd.exec)
        begin
            res_status_reg <= res_status_next;
            res_gc_reg     <= res_gc_next;
            res_gi_reg     <= res_gi_next;
            res_fc_reg     <= res_fc_next;
        end
    end

    // ---------------- finish step ----------------
    logic [SUM_W-1:0] usage;

    always_comb
    begin
        usage         = (alloc_sum_reg >= freed_sum_reg) ? alloc_sum_reg - freed_sum_reg : '0;
        peak_sum_next = (alloc_ok_reg && usage > peak_sum_reg) ? usage : peak_sum_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                tops_reg[c] <= '0;
                hw_reg[c]   <= '0;
            end
            alloc_sum_reg <= '0;
            freed_sum_reg <= '0;
            peak_sum_reg  <= '0;
            alloc_ok_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.exec)
            begin
                alloc_sum_reg <= alloc_sum_next;
                freed_sum_reg <= freed_sum_next;
                alloc_ok_reg  <= alloc_ok_next;
                if (tab_we)
                begin
                    tops_reg[cls_reg] <= tops_next;
                    hw_reg[cls_reg]   <= hw_next;
                end
            end
            if (cmd.finish)
            begin
                peak_sum_reg <= peak_sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_status_reg <= res_status_reg;
            out_gc_reg     <= res_gc_reg;
            out_gi_reg     <= res_gi_reg;
            out_fc_reg     <= res_fc_reg;
            out_total_reg  <= alloc_sum_reg;
            out_peak_reg   <= peak_sum_next;
        end
    end

    assign stat.out_slot_free        = !out_valid_reg || out_ready;
    assign out_valid                 = out_valid_reg;
    assign out_status                = out_status_reg;
    assign out_granted_class         = out_gc_reg;
    assign out_granted_index         = out_gi_reg;
    assign out_class_free_count      = out_fc_reg;
    assign out_bytes_allocated_total = out_total_reg;
    assign out_bytes_peak_in_use     = out_peak_reg;

endmodule

FILE: rtl/size_class_block_pool.sv
// Channel  Dir  tvalid/tready         tdata / tuser
// s_axis   in   s_tvalid, s_tready    tdata: request_bytes, handle_class, handle_index
//                                     tuser: command
// m_axis   out  m_tvalid, m_tready    tdata: granted_class, granted_index,
//                                            class_free_count, bytes_allocated_total,
//                                            bytes_peak_in_use; tuser: status
//
// A request reads the class stack and in-use tables at accept and updates them in the
// exec step; the peak compare and output load overlap the next word's accept.
// The two table memories each have one read and one write port.
// Reset is asynchronous, active low, and needs no clearing pass: per-class
// high-water marks stand in for the reset contents of both tables.
// A result waiting in the output register does not block the next accept; a second
// result waits in place, holding s_tready low, until m_tready frees the register.
module size_class_block_pool
#(
    parameter int NUM_CLASSES          = szc_pkg::DEF_NUM_CLASSES,
    parameter int TOTAL_BLOCKS         = szc_pkg::DEF_TOTAL_BLOCKS,
    parameter int SMALLEST_BLOCK_BYTES = szc_pkg::DEF_SMALLEST_BLOCK_BYTES
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [19:0] request_bytes, [22:20] handle_class, [28:23] handle_index, [31:29] zero
    input  logic [szc_pkg::IN_DATA_W-1:0]       s_tdata,
    // [0] command
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [2:0] granted_class, [8:3] granted_index, [15:9] class_free_count,
    // [63:16] bytes_allocated_total, [111:64] bytes_peak_in_use
    output logic [szc_pkg::OUT_DATA_W-1:0]      m_tdata,
    // [2:0] status
    output logic [szc_pkg::STATUS_W-1:0]        m_tuser
);

    szc_pkg::ctrl_cmd_t  cmd;
    szc_pkg::ctrl_stat_t stat;

    logic [szc_pkg::HCLS_W-1:0] out_gc;
    logic [szc_pkg::HIDX_W-1:0] out_gi;
    logic [szc_pkg::FCNT_W-1:0] out_fc;
    logic [szc_pkg::SUM_W-1:0]  out_total;
    logic [szc_pkg::SUM_W-1:0]  out_peak;

    szc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    szc_datapath
    #(
        .NUM_CLASSES          (NUM_CLASSES),
        .TOTAL_BLOCKS         (TOTAL_BLOCKS),
        .SMALLEST_BLOCK_BYTES (SMALLEST_BLOCK_BYTES)
    )
    u_datapath
    (
        .clk                       (clk),
        .rst_n                     (rst_n),
        .cmd                       (cmd),
        .stat                      (stat),
        .in_command                (s_tuser),
        .in_request_bytes          (s_tdata[19:0]),
        .in_handle_class           (s_tdata[22:20]),
        .in_handle_index           (s_tdata[28:23]),
        .out_valid                 (m_tvalid),
        .out_ready                 (m_tready),
        .out_status                (m_tuser),
        .out_granted_class         (out_gc),
        .out_granted_index         (out_gi),
        .out_class_free_count      (out_fc),
        .out_bytes_allocated_total (out_total),
        .out_bytes_peak_in_use     (out_peak)
    );

    assign m_tdata = {out_peak, out_total, out_fc, out_gi, out_gc};

endmodule

FILE: bench/size_class_block_pool_check.sv
`timescale 1ns / 100ps

module size_class_block_pool_check
#(
    parameter int NUM_CLASSES          = szc_pkg::DEF_NUM_CLASSES,
    parameter int TOTAL_BLOCKS         = szc_pkg::DEF_TOTAL_BLOCKS,
    parameter int SMALLEST_BLOCK_BYTES = szc_pkg::DEF_SMALLEST_BLOCK_BYTES
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [szc_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [szc_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic [szc_pkg::STATUS_W-1:0]    m_tuser,
    output int                              fail_count,
    output int                              pending,
    output int                              result_count,
    output int                              refused_count,
    output int                              empty_count
);

    localparam int REQ_W  = szc_pkg::REQ_W;
    localparam int HCLS_W = szc_pkg::HCLS_W;
    localparam int HIDX_W = szc_pkg::HIDX_W;
    localparam int FCNT_W = szc_pkg::FCNT_W;
    localparam int SUM_W  = szc_pkg::SUM_W;

    localparam int CAP = TOTAL_BLOCKS / NUM_CLASSES;
    localparam logic [63:0] SUM_LIMIT = 64'hFFFF_FFFF_FFFF;

    typedef struct
    {
        szc_pkg::status_t    status;
        logic [HCLS_W-1:0]   cls;
        logic [HIDX_W-1:0]   idx;
        logic [FCNT_W-1:0]   free_cnt;
        logic [SUM_W-1:0]    granted_total;
        logic [SUM_W-1:0]    peak;
    } pool_reply_t;

    // Pool shadow: per-class free-index stacks, popped counts, in-use bits, byte sums
    logic [15:0] idx_stack [TOTAL_BLOCKS];
    int          taken     [NUM_CLASSES];
    logic        busy      [TOTAL_BLOCKS];
    logic [63:0] granted_bytes;
    logic [63:0] returned_bytes;
    logic [63:0] high_water;

    pool_reply_t owed [$];
    int          errs;
    int          checked;
    int          refused;
    int          empties;

    function automatic logic [63:0] block_bytes(int c);
        return 64'(SMALLEST_BLOCK_BYTES) << c;
    endfunction

    function automatic logic [63:0] capped_sum(logic [63:0] a, logic [63:0] b);
        if (a >= SUM_LIMIT || b > SUM_LIMIT - a)
            return SUM_LIMIT;
        return a + b;
    endfunction

    function automatic int blocks_left(int c);
        return (taken[c] >= CAP) ? 0 : CAP - taken[c];
    endfunction

    function automatic pool_reply_t pool_apply(szc_pkg::command_t cmd,
                                               logic [REQ_W-1:0] bytes,
                                               logic [HCLS_W-1:0] hc, logic [HIDX_W-1:0] hi);
        pool_reply_t r;
        int          c;
        int          slot;
        logic [63:0] usage;
        r.status   = szc_pkg::ST_OK;
        r.cls      = '0;
        r.idx      = '0;
        r.free_cnt = '0;
        if (cmd == szc_pkg::CMD_ALLOC)
        begin
            if (bytes == '0)
                r.status = szc_pkg::ST_ZERO_SIZE;
            else
            begin
                c = 0;
                while (c < NUM_CLASSES && 64'(bytes) > block_bytes(c))
                    c++;
                if (c >= NUM_CLASSES)
                    r.status = szc_pkg::ST_TOO_LARGE;
                else if (taken[c] >= CAP)
                begin
                    r.status = szc_pkg::ST_CLASS_EMPTY;
                    r.cls    = HCLS_W'(c);
                end
                else
                begin
                    slot = int'(idx_stack[c * CAP + taken[c]]) % CAP;
                    taken[c]++;
                    busy[c * CAP + slot] = 1'b1;
                    granted_bytes = capped_sum(granted_bytes, block_bytes(c));
                    usage = (granted_bytes >= returned_bytes) ?
                            granted_bytes - returned_bytes : '0;
                    if (usage > high_water)
                        high_water = usage;
                    r.cls      = HCLS_W'(c);
                    r.idx      = HIDX_W'(slot);
                    r.free_cnt = FCNT_W'(blocks_left(c));
                end
            end
        end
        else
        begin
            r.cls = hc;
            r.idx = hi;
            c     = int'(hc);
            slot  = int'(hi);
            // out-of-range handles cannot be encoded at the default sizes, kept for other ones
            if (c >= NUM_CLASSES)
                r.status = szc_pkg::ST_BAD_HANDLE;
            else if (slot >= CAP)
            begin
                r.status   = szc_pkg::ST_BAD_HANDLE;
                r.free_cnt = FCNT_W'(blocks_left(c));
            end
            else if (!busy[c * CAP + slot] || taken[c] == 0)
            begin
                r.status   = szc_pkg::ST_NOT_IN_USE;
                r.free_cnt = FCNT_W'(blocks_left(c));
            end
            else
            begin
                busy[c * CAP + slot] = 1'b0;
                taken[c]--;
                idx_stack[c * CAP + taken[c]] = 16'(slot);
                returned_bytes = capped_sum(returned_bytes, block_bytes(c));
                r.free_cnt = FCNT_W'(blocks_left(c));
            end
        end
        r.granted_total = granted_bytes[SUM_W-1:0];
        r.peak          = high_water[SUM_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string name, logic [SUM_W-1:0] want,
                                        logic [SUM_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errs++;
        end
    endfunction

    initial
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            taken[c] = 0;
            for (int j = 0; j < CAP; j++)
            begin
                idx_stack[c * CAP + j] = 16'(j);
                busy[c * CAP + j]      = 1'b0;
            end
        end
        granted_bytes  = '0;
        returned_bytes = '0;
        high_water     = '0;
        errs           = 0;
        checked        = 0;
        refused        = 0;
        empties        = 0;
        fail_count     = 0;
        pending        = 0;
        result_count   = 0;
        refused_count  = 0;
        empty_count    = 0;
    end

    always @(posedge clk)
    begin
        pool_reply_t want;
        if (rst_n)
        begin
            // retire the oldest expectation before taking in a new word
            if (m_tvalid && m_tready)
            begin
                if (owed.size() == 0)
                begin
                    $error("result word with nothing outstanding: status %0d", m_tuser);
                    errs++;
                end
                else
                begin
                    want = owed.pop_front();
                    checked++;
                    check_field("status", SUM_W'(want.status), SUM_W'(m_tuser));
                    check_field("granted_class", SUM_W'(want.cls), SUM_W'(m_tdata[2:0]));
                    check_field("granted_index", SUM_W'(want.idx), SUM_W'(m_tdata[8:3]));
                    check_field("class_free_count", SUM_W'(want.free_cnt),
                                SUM_W'(m_tdata[15:9]));
                    check_field("bytes_allocated_total", want.granted_total,
                                m_tdata[63:16]);
                    check_field("bytes_peak_in_use", want.peak, m_tdata[111:64]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = pool_apply(szc_pkg::command_t'(s_tuser), s_tdata[19:0],
                                  s_tdata[22:20], s_tdata[28:23]);
                if (want.status != szc_pkg::ST_OK)
                    refused++;
                if (want.status == szc_pkg::ST_CLASS_EMPTY)
                    empties++;
                owed.push_back(want);
            end
        end
        fail_count    <= errs;
        pending       <= owed.size();
        result_count  <= checked;
        refused_count <= refused;
        empty_count   <= empties;
    end

endmodule

FILE: bench/size_class_block_pool_test.sv
`timescale 1ns / 100ps

module size_class_block_pool_test;

    localparam int REQ_W  = szc_pkg::REQ_W;
    localparam int HCLS_W = szc_pkg::HCLS_W;
    localparam int HIDX_W = szc_pkg::HIDX_W;

    localparam int DEF_NUM_CLASSES          = szc_pkg::DEF_NUM_CLASSES;
    localparam int DEF_SMALLEST_BLOCK_BYTES = szc_pkg::DEF_SMALLEST_BLOCK_BYTES;

    localparam int ITEMS     = 1150;
    localparam int LIMIT     = 400000;
    localparam int HOLD_LONG = 300;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [szc_pkg::IN_DATA_W-1:0]       s_tdata;
    logic                                s_tuser;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [szc_pkg::OUT_DATA_W-1:0]      m_tdata;
    logic [szc_pkg::STATUS_W-1:0]        m_tuser;

    int fail_count;
    int pending;
    int result_count;
    int refused_count;
    int empty_count;

    int                sent = 0;
    int                cycles = 0;
    logic              steady = 1'b0;
    int                holds_asked = 0;
    int                holds_granted = 0;
    int                hold_left = 0;
    szc_pkg::command_t sent_cmds [$];
    szc_pkg::command_t done_cmd;
    logic [8:0]        held [$];    // {index, class} of blocks known to be allocated

    size_class_block_pool u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    size_class_block_pool_check u_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .result_count  (result_count),
        .refused_count (refused_count),
        .empty_count   (empty_count)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: random back-pressure, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (holds_granted != holds_asked)
        begin
            holds_granted <= holds_asked;
            hold_left     <= HOLD_LONG;
            m_tready      <= 1'b0;
        end
        else
            m_tready <= steady || ($urandom_range(0, 99) >= 6);
    end

    // Learn granted handles so that frees mostly name live blocks
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready && sent_cmds.size() != 0)
            begin
                done_cmd = sent_cmds.pop_front();
                if (done_cmd == szc_pkg::CMD_ALLOC && m_tuser == szc_pkg::ST_OK)
                    held.push_back(m_tdata[8:0]);
            end
            if (s_tvalid && s_tready)
                sent_cmds.push_back(szc_pkg::command_t'(s_tuser));
        end
    end

    task automatic send_word(input szc_pkg::command_t cmd, input logic [REQ_W-1:0] bytes,
                             input logic [HCLS_W-1:0] cls, input logic [HIDX_W-1:0] idx);
        while (!steady && $urandom_range(0, 99) < 6)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, idx, cls, bytes};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic ask_alloc(input logic [REQ_W-1:0] bytes);
        send_word(szc_pkg::CMD_ALLOC, bytes, HCLS_W'($urandom_range(0, 7)),
                  HIDX_W'($urandom_range(0, 63)));
    endtask

    task automatic ask_free(input logic [HCLS_W-1:0] cls, input logic [HIDX_W-1:0] idx);
        send_word(szc_pkg::CMD_FREE, REQ_W'($urandom_range(0, 20'hFFFFF)), cls, idx);
    endtask

    task automatic ask_free_any;
        ask_free(HCLS_W'($urandom_range(0, 7)), HIDX_W'($urandom_range(0, 63)));
    endtask

    // Free a live block when one is known; now and then free it twice
    task automatic free_one_held;
        logic [8:0] h;
        int         k;
        if (held.size() == 0)
            ask_free_any();
        else
        begin
            k = $urandom_range(0, held.size() - 1);
            h = held[k];
            held.delete(k);
            ask_free(h[2:0], h[8:3]);
            if ($urandom_range(0, 11) == 0)
                ask_free(h[2:0], h[8:3]);
        end
    endtask

    // Request size that maps to class c, weighted toward the class edges
    function automatic logic [REQ_W-1:0] size_in_class(int c);
        int lo;
        int hi;
        int pick;
        lo   = (c == 0) ? 1 : (DEF_SMALLEST_BLOCK_BYTES << (c - 1)) + 1;
        hi   = DEF_SMALLEST_BLOCK_BYTES << c;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            return REQ_W'(lo);
        if (pick == 1)
            return REQ_W'(hi);
        return REQ_W'($urandom_range(lo, hi));
    endfunction

    function automatic logic [REQ_W-1:0] oversize();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            return REQ_W'((DEF_SMALLEST_BLOCK_BYTES << (DEF_NUM_CLASSES - 1)) + 1);
        if (pick == 1)
            return '1;
        return REQ_W'($urandom_range((DEF_SMALLEST_BLOCK_BYTES << (DEF_NUM_CLASSES - 1)) + 1,
                                     20'hFFFFF));
    endfunction

    initial
    begin
        int episode;
        int mode;
        int n;
        int c;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = szc_pkg::CMD_ALLOC;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: size edges, every class, both frees of a block, LIFO reuse
        ask_alloc('0);
        ask_alloc(20'd1);
        ask_alloc(20'd16);
        ask_alloc(20'd17);
        ask_alloc(20'd32);
        ask_alloc(20'd64);
        ask_alloc(20'd128);
        ask_alloc(20'd256);
        ask_alloc(20'd512);
        ask_alloc(20'd1024);
        ask_alloc(20'd2048);
        ask_alloc(20'd2049);
        ask_alloc(20'hFFFFF);
        ask_free(3'd0, 6'd0);
        ask_free(3'd0, 6'd0);
        ask_free(3'd7, 6'd63);
        ask_free(3'd2, 6'd3);
        ask_free(3'd4, 6'd0);
        ask_alloc(20'd16);
        ask_free(3'd7, 6'd0);
        ask_free(3'd7, 6'd0);

        episode = 0;
        while (sent < ITEMS)
        begin
            steady <= (sent >= 450 && sent < 650);
            if (episode == 4 || episode == 22)
                holds_asked <= holds_asked + 1;
            if (episode == 14)
            begin
                // hold the sender until the pipe is empty
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (pending != 0);
            end
            mode = (episode == 0) ? 0 : $urandom_range(0, 9);
            if (mode <= 1)
            begin
                // exhaust one class and keep asking
                c = (episode == 0) ? 7 : $urandom_range(0, 7);
                n = $urandom_range(66, 72);
                repeat (n)
                    ask_alloc(size_in_class(c));
            end
            else if (mode <= 4)
            begin
                n = $urandom_range(15, 45);
                repeat (n)
                    free_one_held();
            end
            else
            begin
                n = $urandom_range(20, 40);
                repeat (n)
                begin
                    c = $urandom_range(0, 99);
                    if (c < 52)
                        ask_alloc(size_in_class($urandom_range(0, 7)));
                    else if (c < 88)
                        free_one_held();
                    else if (c < 92)
                        ask_alloc('0);
                    else if (c < 96)
                        ask_alloc(oversize());
                    else
                        ask_free_any();
                end
            end
            episode++;
        end

        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);

        $display("%0d requests sent, %0d results checked against the pool shadow",
                 sent, result_count);
        $display("%0d requests refused, %0d of them on an exhausted class",
                 refused_count, empty_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
